// ===== rtl/swmf_pkg.sv =====
// Shared types and constants of the square window max filter.
package swmf_pkg;

	localparam int unsigned PIX_W        = 8;
	localparam int unsigned ROW_W        = 16;
	localparam int unsigned CFG_IDX_W    = 2;
	localparam int unsigned CFG_DATA_W   = 16;
	localparam int unsigned RAD_W        = 5;
	localparam int unsigned WID_FIELD_W  = 11;
	localparam int unsigned WID_RESET    = 640;
	localparam int unsigned HGT_RESET    = 480;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH   = 2'd0,
		CFG_FRAME_HEIGHT  = 2'd1,
		CFG_WINDOW_RADIUS = 2'd2,
		CFG_UNUSED        = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIN  = 3'b100
	} back_st_t;

endpackage

// ===== rtl/swmf_if.sv =====
// Channel interfaces: pixel input, result output and configuration writes.
interface swmf_in_if;
	logic                       valid;
	logic                       ready;
	logic                       operation;
	logic [swmf_pkg::PIX_W-1:0] pixel_in;
	modport source (output valid, output operation, output pixel_in, input ready);
	modport sink (input valid, input operation, input pixel_in, output ready);
endinterface

interface swmf_out_if;
	logic                       valid;
	logic                       ready;
	logic [swmf_pkg::PIX_W-1:0] pixel_out;
	logic                       last_of_frame;
	modport source (output valid, output pixel_out, output last_of_frame, input ready);
	modport sink (input valid, input pixel_out, input last_of_frame, output ready);
endinterface

interface swmf_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [swmf_pkg::CFG_IDX_W-1:0]  index;
	logic [swmf_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/swmf_queue.sv =====
// Two-entry job queue between the front and back parts.
module swmf_queue #(
	parameter int unsigned W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output logic [W-1:0] pop_data
);
	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign pop_data  = mem_q[rp_q];
endmodule

// ===== rtl/swmf_front.sv =====
// Front part: configuration, input and output position tracking, job issue.
module swmf_front #(
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned MAX_RADIUS = 29
) (
	input  logic clk,
	input  logic arst_n,
	swmf_in_if.sink  din,
	swmf_cfg_if.sink cfg,
	input  logic back_idle,
	input  logic q_not_empty,
	input  logic q_full,
	output logic job_push,
	output logic [2*$clog2(2*MAX_RADIUS+2)+2*$clog2(MAX_WIDTH):0] job_data,
	output logic wr_en,
	output logic [$clog2(2*MAX_RADIUS+2)-1:0] wr_slot,
	output logic [$clog2(MAX_WIDTH)-1:0] wr_col,
	output logic [swmf_pkg::PIX_W-1:0] wr_pix
);
	localparam int unsigned LS = 2 * MAX_RADIUS + 2;
	localparam int unsigned SW = $clog2(LS);
	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned RW = swmf_pkg::ROW_W;
	localparam int unsigned WID_RST =
		swmf_pkg::WID_RESET > MAX_WIDTH ? MAX_WIDTH : swmf_pkg::WID_RESET;

	logic [WW-1:0] wid_q;
	logic [RW-1:0] hgt_q;
	logic [swmf_pkg::RAD_W-1:0] rad_q;
	logic [CW-1:0] icol_q, ocol_q;
	logic [RW-1:0] irow_q, orow_q;
	logic [SW-1:0] islot_q, oslot_q;
	logic          done_q;

	logic          accept, is_pix, cfg_wr;
	logic [WW-1:0] wm1;
	logic [RW-1:0] hm1;
	logic [CW-1:0] icol_n, ocol0, ocol_n;
	logic [RW-1:0] irow_n, orow0, orow_n;
	logic [SW-1:0] islot_n, oslot0, oslot_n, r0_slot;
	logic          done_a, done_n, rdy, last;
	logic [RW:0]   nrow_w;
	logic [RW-1:0] nrow, r0;
	logic [WW:0]   ncol_w;
	logic [CW-1:0] ncol, c0;
	logic [10:0]   wv;
	logic [swmf_pkg::RAD_W-1:0] rv;

	// A pending register write holds off the input so that no transaction is
	// taken in the same cycle as a frame restart.
	assign din.ready = !q_not_empty && !q_full && back_idle && !cfg.valid;
	assign cfg.ready = 1'b1;
	assign accept    = din.valid && din.ready;
	assign is_pix    = din.operation == swmf_pkg::OP_PIXEL;
	assign cfg_wr    = cfg.valid && cfg.index != swmf_pkg::CFG_UNUSED;

	assign wm1 = wid_q - WW'(1);
	assign hm1 = hgt_q - RW'(1);

	always_comb begin
		// A pixel after a fully received plane starts the next plane.
		done_a = done_q;
		ocol0  = ocol_q;
		orow0  = orow_q;
		oslot0 = oslot_q;
		icol_n = icol_q;
		irow_n = irow_q;
		islot_n = islot_q;
		if (is_pix) begin
			if (done_q) begin
				done_a = 1'b0;
				ocol0  = '0;
				orow0  = '0;
				oslot0 = '0;
			end
			if (WW'(icol_q) == wm1) begin
				icol_n = '0;
				if (irow_q == hm1) begin
					irow_n  = '0;
					islot_n = '0;
					done_a  = 1'b1;
				end else begin
					irow_n  = irow_q + RW'(1);
					islot_n = (islot_q == SW'(LS - 1)) ? '0 : islot_q + SW'(1);
				end
			end else begin
				icol_n = icol_q + CW'(1);
			end
		end

		nrow_w = {1'b0, orow0} + (RW+1)'(rad_q);
		nrow   = (nrow_w > {1'b0, hm1}) ? hm1 : nrow_w[RW-1:0];
		ncol_w = {1'b0, WW'(ocol0)} + (WW+1)'(rad_q);
		ncol   = (ncol_w > {1'b0, wm1}) ? CW'(wm1) : CW'(ncol_w);
		rdy    = done_a || (nrow < irow_n) ||
			(nrow == irow_n && WW'(ncol) < WW'(icol_n));
		last   = (orow0 == hm1) && (WW'(ocol0) == wm1);

		r0      = (orow0 > RW'(rad_q)) ? orow0 - RW'(rad_q) : '0;
		r0_slot = '0;
		if (orow0 > RW'(rad_q))
			r0_slot = (oslot0 >= SW'(rad_q)) ? oslot0 - SW'(rad_q)
				: oslot0 + SW'(LS) - SW'(rad_q);
		c0 = (WW'(ocol0) > WW'(rad_q)) ? ocol0 - CW'(rad_q) : '0;

		done_n  = done_a;
		ocol_n  = ocol0;
		orow_n  = orow0;
		oslot_n = oslot0;
		if (rdy) begin
			if (last) begin
				done_n  = 1'b0;
				ocol_n  = '0;
				orow_n  = '0;
				oslot_n = '0;
			end else if (WW'(ocol0) == wm1) begin
				ocol_n  = '0;
				orow_n  = orow0 + RW'(1);
				oslot_n = (oslot0 == SW'(LS - 1)) ? '0 : oslot0 + SW'(1);
			end else begin
				ocol_n = ocol0 + CW'(1);
			end
		end

		wv = cfg.data[10:0];
		rv = cfg.data[swmf_pkg::RAD_W-1:0];
	end

	assign job_push = accept && rdy;
	assign job_data = {r0_slot, SW'(nrow - r0), c0, ncol, last};
	assign wr_en    = accept && is_pix;
	assign wr_slot  = islot_q;
	assign wr_col   = icol_q;
	assign wr_pix   = din.pixel_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wid_q   <= WW'(WID_RST);
			hgt_q   <= RW'(swmf_pkg::HGT_RESET);
			rad_q   <= '0;
			icol_q  <= '0;
			irow_q  <= '0;
			islot_q <= '0;
			ocol_q  <= '0;
			orow_q  <= '0;
			oslot_q <= '0;
			done_q  <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg.index)
				swmf_pkg::CFG_FRAME_WIDTH: begin
					if (wv == 11'd0) wid_q <= WW'(1);
					else if (13'(wv) > 13'(MAX_WIDTH)) wid_q <= WW'(MAX_WIDTH);
					else wid_q <= WW'(wv);
				end
				swmf_pkg::CFG_FRAME_HEIGHT:
					hgt_q <= (cfg.data == '0) ? RW'(1) : cfg.data;
				swmf_pkg::CFG_WINDOW_RADIUS:
					rad_q <= (rv > swmf_pkg::RAD_W'(MAX_RADIUS))
						? swmf_pkg::RAD_W'(MAX_RADIUS) : rv;
				default: ;
			endcase
			icol_q  <= '0;
			irow_q  <= '0;
			islot_q <= '0;
			ocol_q  <= '0;
			orow_q  <= '0;
			oslot_q <= '0;
			done_q  <= 1'b0;
		end else if (accept) begin
			icol_q  <= icol_n;
			irow_q  <= irow_n;
			islot_q <= islot_n;
			ocol_q  <= ocol_n;
			orow_q  <= orow_n;
			oslot_q <= oslot_n;
			done_q  <= done_n;
		end
	end
endmodule

// ===== rtl/swmf_back.sv =====
// Back part: line store and the iterative window maximum scan.
module swmf_back #(
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned MAX_RADIUS = 29
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [$clog2(2*MAX_RADIUS+2)-1:0] wr_slot,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
	input  logic [swmf_pkg::PIX_W-1:0] wr_pix,
	input  logic q_not_empty,
	input  logic [2*$clog2(2*MAX_RADIUS+2)+2*$clog2(MAX_WIDTH):0] q_data,
	output logic q_pop,
	output logic idle,
	swmf_out_if.source dout
);
	localparam int unsigned LS = 2 * MAX_RADIUS + 2;
	localparam int unsigned SW = $clog2(LS);
	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned AW = $clog2(LS * MAX_WIDTH);
	localparam int unsigned PW = swmf_pkg::PIX_W;

	logic [PW-1:0] mem [LS * MAX_WIDTH];

	swmf_pkg::back_st_t st_q;
	logic [SW-1:0] slot_q, rows_q;
	logic [CW-1:0] col_q, c0_q, c1_q;
	logic          last_q, rd_vld_q, out_vld_q, out_last_q;
	logic [PW-1:0] best_q, rdata_q, out_pix_q, best_n;
	logic [AW-1:0] rd_addr, wr_addr;

	assign wr_addr = AW'(wr_slot) * AW'(MAX_WIDTH) + AW'(wr_col);
	assign rd_addr = AW'(slot_q) * AW'(MAX_WIDTH) + AW'(col_q);

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_pix;
		rdata_q <= mem[rd_addr];
	end

	assign best_n = (rd_vld_q && rdata_q > best_q) ? rdata_q : best_q;
	assign idle   = st_q == swmf_pkg::ST_IDLE;
	assign q_pop  = idle && q_not_empty && !out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= swmf_pkg::ST_IDLE;
			rd_vld_q   <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			rd_vld_q <= st_q == swmf_pkg::ST_RUN;
			if (dout.valid && dout.ready) out_vld_q <= 1'b0;
			unique case (st_q)
				swmf_pkg::ST_IDLE: begin
					if (q_pop) st_q <= swmf_pkg::ST_RUN;
				end
				swmf_pkg::ST_RUN: begin
					if (col_q == c1_q && rows_q == '0) st_q <= swmf_pkg::ST_FIN;
				end
				swmf_pkg::ST_FIN: begin
					out_vld_q <= 1'b1;
					st_q      <= swmf_pkg::ST_IDLE;
				end
				default: st_q <= swmf_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			{slot_q, rows_q, c0_q, c1_q, last_q} <= q_data;
			col_q  <= q_data[2*CW:CW+1];
			best_q <= '0;
		end else begin
			best_q <= best_n;
			if (st_q == swmf_pkg::ST_RUN) begin
				if (col_q == c1_q) begin
					col_q  <= c0_q;
					rows_q <= rows_q - SW'(1);
					slot_q <= (slot_q == SW'(LS - 1)) ? '0 : slot_q + SW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
		if (st_q == swmf_pkg::ST_FIN) begin
			out_pix_q  <= best_n;
			out_last_q <= last_q;
		end
	end

	assign dout.valid         = out_vld_q;
	assign dout.pixel_out     = out_pix_q;
	assign dout.last_of_frame = out_last_q;

	a_fin_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == swmf_pkg::ST_FIN |-> rd_vld_q)
		else $error("final scan cycle without read data");
	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !out_vld_q && st_q == swmf_pkg::ST_IDLE)
		else $error("job started while busy or result pending");
	a_fin_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == swmf_pkg::ST_FIN |=> out_vld_q)
		else $error("scan finished without a result");
endmodule

// ===== rtl/square_window_max_filter.sv =====
// Top level of the square window max filter (grayscale dilation).
//
// Channel  Direction  Payload                       Transaction when
// din      in         operation, pixel_in           din.valid && din.ready
// dout     out        pixel_out, last_of_frame      dout.valid && dout.ready
// cfg      in         index, data                   cfg.valid && cfg.ready
//
// Flow: the front classifies an input transaction combinationally in the cycle it is
// taken. When it makes an output ready, the back scans the clipped window out of the
// line store one pixel a cycle through its single read port and then registers the
// result. Reset clears positions and control; the line store needs no clearing because
// only entries written in the current frame are ever read. The front takes a new
// transaction while a result waits in the output register; it stalls during a scan
// and while a job waits in the queue.
module square_window_max_filter #(
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned MAX_RADIUS = 29
) (
	input logic clk,
	input logic arst_n,
	swmf_in_if.sink    din,
	swmf_out_if.source dout,
	swmf_cfg_if.sink   cfg
);
	localparam int unsigned SW = $clog2(2 * MAX_RADIUS + 2);
	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned JW = 2 * SW + 2 * CW + 1;

	logic          back_idle, q_not_empty, q_full, job_push, q_pop, wr_en;
	logic [JW-1:0] job_data, q_data;
	logic [SW-1:0] wr_slot;
	logic [CW-1:0] wr_col;
	logic [swmf_pkg::PIX_W-1:0] wr_pix;

	// The front owns all position state and decides per transaction whether
	// an output becomes due; it hands the window bounds to the back as a job.
	swmf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_front (
		.clk, .arst_n, .din, .cfg,
		.back_idle, .q_not_empty, .q_full,
		.job_push, .job_data,
		.wr_en, .wr_slot, .wr_col, .wr_pix
	);

	swmf_queue #(.W(JW)) u_queue (
		.clk, .arst_n,
		.push(job_push), .push_data(job_data), .full(q_full),
		.pop(q_pop), .not_empty(q_not_empty), .pop_data(q_data)
	);

	// The back holds the line store and reduces each job's window to its maximum.
	swmf_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_back (
		.clk, .arst_n,
		.wr_en, .wr_slot, .wr_col, .wr_pix,
		.q_not_empty, .q_data, .q_pop,
		.idle(back_idle), .dout
	);
endmodule

// ===== verif/testbench.sv =====
// Testbench of the square window max filter: directed table, then random frames.
module testbench;

	localparam int unsigned MAX_WIDTH  = 1024;
	localparam int unsigned MAX_RADIUS = 29;
	localparam int unsigned LS_ROWS    = 2 * MAX_RADIUS + 2;
	// The longest scan covers a full window, so this covers any tail with margin.
	localparam int unsigned SETTLE     = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 120;
	localparam int unsigned RAND_ITEMS = 750;

	typedef struct packed {
		logic [swmf_pkg::PIX_W-1:0] pix;
		logic                       last;
	} dil_result_t;

	// One row of the directed table. A row either writes a register or sends a
	// transaction; typed rows carry the result that can be read off directly.
	typedef struct {
		bit                         is_cfg;
		swmf_pkg::cfg_idx_t         idx;
		logic [15:0]                val;
		swmf_pkg::op_t              op;
		logic [swmf_pkg::PIX_W-1:0] pix;
		bit                         typed;
		bit                         has_res;
		logic [swmf_pkg::PIX_W-1:0] res_pix;
		logic                       res_last;
	} dir_row_t;

	logic clk;
	logic arst_n;

	swmf_in_if  din_if ();
	swmf_out_if dout_if ();
	swmf_cfg_if cfg_if ();

	square_window_max_filter #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_RADIUS(MAX_RADIUS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din_if.sink),
		.dout  (dout_if.source),
		.cfg   (cfg_if.sink)
	);

	// Shadow of the filter state, updated at every accepted transaction.
	logic [swmf_pkg::PIX_W-1:0] shadow_lines [0:LS_ROWS*MAX_WIDTH-1];
	int unsigned      sh_width, sh_height, sh_radius;
	int unsigned      sh_in_col, sh_in_row, sh_out_col, sh_out_row;
	bit               sh_plane_in;

	dil_result_t      dilated_q [$];
	int unsigned      mismatches;
	int unsigned      idle_pct;
	int unsigned      stall_pct;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Give up long after the slowest correct run would have ended.
	initial begin
		#(4 * 4_000_000);
		$display("simulation failed");
		$finish;
	end

	function automatic int unsigned lmin(int unsigned a, int unsigned b);
		return a < b ? a : b;
	endfunction

	function automatic void shadow_restart();
		sh_in_col   = 0;
		sh_in_row   = 0;
		sh_out_col  = 0;
		sh_out_row  = 0;
		sh_plane_in = 1'b0;
	endfunction

	// An output is ready once the bottom right corner of its clipped window
	// has arrived, or once the whole plane is in.
	function automatic bit window_complete();
		int unsigned nr, nc;
		nr = lmin(sh_out_row + sh_radius, sh_height - 1);
		nc = lmin(sh_out_col + sh_radius, sh_width - 1);
		if (sh_plane_in)
			return 1'b1;
		if (nr < sh_in_row)
			return 1'b1;
		return nr == sh_in_row && nc < sh_in_col;
	endfunction

	function automatic bit next_dilated(output dil_result_t res);
		int unsigned r0, r1, c0, c1;
		logic [swmf_pkg::PIX_W-1:0] best;
		if (!window_complete())
			return 1'b0;
		r0 = sh_out_row > sh_radius ? sh_out_row - sh_radius : 0;
		r1 = lmin(sh_out_row + sh_radius, sh_height - 1);
		c0 = sh_out_col > sh_radius ? sh_out_col - sh_radius : 0;
		c1 = lmin(sh_out_col + sh_radius, sh_width - 1);
		best = '0;
		for (int unsigned r = r0; r <= r1; r++)
			for (int unsigned c = c0; c <= c1; c++)
				if (shadow_lines[(r % LS_ROWS) * MAX_WIDTH + c] > best)
					best = shadow_lines[(r % LS_ROWS) * MAX_WIDTH + c];
		res.pix  = best;
		res.last = (sh_out_row == sh_height - 1) && (sh_out_col == sh_width - 1);
		if (res.last) begin
			sh_out_row  = 0;
			sh_out_col  = 0;
			sh_plane_in = 1'b0;
		end else if (sh_out_col + 1 >= sh_width) begin
			sh_out_col = 0;
			sh_out_row++;
		end else begin
			sh_out_col++;
		end
		return 1'b1;
	endfunction

	// Advance the shadow by one accepted input transaction.
	function automatic bit dilate_step(swmf_pkg::op_t op, logic [swmf_pkg::PIX_W-1:0] pix,
			output dil_result_t res);
		if (op == swmf_pkg::OP_FLUSH)
			return next_dilated(res);
		// A pixel after a complete plane starts the next one; pending outputs go.
		if (sh_plane_in) begin
			sh_out_row  = 0;
			sh_out_col  = 0;
			sh_plane_in = 1'b0;
		end
		shadow_lines[(sh_in_row % LS_ROWS) * MAX_WIDTH + sh_in_col] = pix;
		if (sh_in_col + 1 >= sh_width) begin
			sh_in_col = 0;
			if (sh_in_row + 1 >= sh_height) begin
				sh_in_row   = 0;
				sh_plane_in = 1'b1;
			end else begin
				sh_in_row++;
			end
		end else begin
			sh_in_col++;
		end
		return next_dilated(res);
	endfunction

	function automatic void shadow_config(swmf_pkg::cfg_idx_t idx, logic [15:0] val);
		int unsigned v;
		case (idx)
			swmf_pkg::CFG_FRAME_WIDTH: begin
				v = 32'(val[swmf_pkg::WID_FIELD_W-1:0]);
				if (v == 0)
					v = 1;
				sh_width = v > MAX_WIDTH ? MAX_WIDTH : v;
			end
			swmf_pkg::CFG_FRAME_HEIGHT: begin
				sh_height = (val == 16'd0) ? 1 : 32'(val);
			end
			swmf_pkg::CFG_WINDOW_RADIUS: begin
				v = 32'(val[swmf_pkg::RAD_W-1:0]);
				sh_radius = v > MAX_RADIUS ? MAX_RADIUS : v;
			end
			default: return;
		endcase
		shadow_restart();
	endfunction

	// Send one transaction; the sender idles first at the current rate. The
	// shadow is stepped at the edge where the transaction is taken.
	task automatic send_item(swmf_pkg::op_t op, logic [swmf_pkg::PIX_W-1:0] pix,
			bit typed = 0, bit has_res = 0, dil_result_t typed_res = '0);
		dil_result_t res;
		bit          got;
		if ($urandom_range(99) < idle_pct) begin
			din_if.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		din_if.valid     <= 1'b1;
		din_if.operation <= op;
		din_if.pixel_in  <= pix;
		@(posedge clk);
		while (!din_if.ready)
			@(posedge clk);
		got = dilate_step(op, pix, res);
		if (typed) begin
			got = has_res;
			res = typed_res;
		end
		if (got)
			dilated_q.push_back(res);
	endtask

	// Wait until every expected result is out and any scan has finished.
	task automatic drain_block();
		din_if.valid <= 1'b0;
		@(posedge clk);
		while (dilated_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(swmf_pkg::cfg_idx_t idx, logic [15:0] val);
		drain_block();
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		shadow_config(idx, val);
	endtask

	// Unused upper data bits are set at random so that they toggle as well.
	task automatic set_frame(int unsigned w, int unsigned h, int unsigned r);
		logic [15:0] d;
		d = 16'($urandom);
		d[swmf_pkg::WID_FIELD_W-1:0] = w[swmf_pkg::WID_FIELD_W-1:0];
		write_reg(swmf_pkg::CFG_FRAME_WIDTH, d);
		write_reg(swmf_pkg::CFG_FRAME_HEIGHT, h[15:0]);
		d = 16'($urandom);
		d[swmf_pkg::RAD_W-1:0] = r[swmf_pkg::RAD_W-1:0];
		write_reg(swmf_pkg::CFG_WINDOW_RADIUS, d);
	endtask

	task automatic flush_out();
		while (window_complete())
			send_item(swmf_pkg::OP_FLUSH, 8'($urandom));
	endtask

	// One plane with random content. Now and then a flush lands mid-frame, the
	// plane is cut short, or the next plane starts before this one is drained.
	task automatic random_plane(inout int unsigned sent, input int unsigned npix);
		int unsigned cut;
		cut = ($urandom_range(99) < 8) ? $urandom_range(npix) : npix;
		for (int unsigned i = 0; i < cut; i++) begin
			if ($urandom_range(99) < 5)
				send_item(swmf_pkg::OP_FLUSH, 8'($urandom));
			send_item(swmf_pkg::OP_PIXEL, 8'($urandom));
			sent++;
		end
		if ($urandom_range(99) < 85)
			flush_out();
	endtask

	// The receiver stalls at the current rate.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout_if.ready <= 1'b0;
		end else begin
			dout_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		dil_result_t want;
		if (arst_n && dout_if.valid && dout_if.ready) begin
			if (dilated_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result pix=%0h last=%0b",
						dout_if.pixel_out, dout_if.last_of_frame);
			end else begin
				want = dilated_q.pop_front();
				if (dout_if.pixel_out !== want.pix || dout_if.last_of_frame !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected pix=%0h last=%0b, got pix=%0h last=%0b",
							want.pix, want.last, dout_if.pixel_out, dout_if.last_of_frame);
				end
			end
		end
	end

	initial begin
		dir_row_t    table_rows [$];
		int unsigned sent;
		int unsigned phase;
		int unsigned w, h, r;
		dil_result_t tr;

		arst_n           = 1'b0;
		din_if.valid     = 1'b0;
		din_if.operation = swmf_pkg::OP_PIXEL;
		din_if.pixel_in  = '0;
		cfg_if.valid     = 1'b0;
		cfg_if.index     = swmf_pkg::CFG_FRAME_WIDTH;
		cfg_if.data      = '0;
		mismatches       = 0;
		idle_pct         = 0;
		stall_pct        = 0;
		for (int i = 0; i < LS_ROWS * MAX_WIDTH; i++)
			shadow_lines[i] = '0;
		sh_width  = swmf_pkg::WID_RESET;
		sh_height = swmf_pkg::HGT_RESET;
		sh_radius = 0;
		shadow_restart();

		// Directed part. After reset the radius is zero, so a pixel comes back
		// as itself. A one pixel frame flags every result as the last one.
		table_rows = '{
			'{0, swmf_pkg::CFG_UNUSED, 0, swmf_pkg::OP_PIXEL, 8'h00, 1, 1, 8'h00, 0},
			'{0, swmf_pkg::CFG_UNUSED, 0, swmf_pkg::OP_PIXEL, 8'hff, 1, 1, 8'hff, 0},
			'{0, swmf_pkg::CFG_UNUSED, 0, swmf_pkg::OP_FLUSH, 8'h3c, 1, 0, 8'h00, 0},
			'{0, swmf_pkg::CFG_UNUSED, 0, swmf_pkg::OP_PIXEL, 8'h5a, 1, 1, 8'h5a, 0},
			'{1, swmf_pkg::CFG_UNUSED, 16'hffff, swmf_pkg::OP_PIXEL, 0, 0, 0, 0, 0},
			'{1, swmf_pkg::CFG_FRAME_WIDTH, 16'h0000, swmf_pkg::OP_PIXEL, 0, 0, 0, 0, 0},
			'{1, swmf_pkg::CFG_FRAME_HEIGHT, 16'h0000, swmf_pkg::OP_PIXEL, 0, 0, 0, 0, 0},
			'{0, swmf_pkg::CFG_UNUSED, 0, swmf_pkg::OP_PIXEL, 8'ha5, 1, 1, 8'ha5, 1},
			'{0, swmf_pkg::CFG_UNUSED, 0, swmf_pkg::OP_PIXEL, 8'h00, 1, 1, 8'h00, 1},
			'{1, swmf_pkg::CFG_WINDOW_RADIUS, 16'h001f, swmf_pkg::OP_PIXEL, 0, 0, 0, 0, 0},
			'{0, swmf_pkg::CFG_UNUSED, 0, swmf_pkg::OP_PIXEL, 8'h4d, 1, 1, 8'h4d, 1},
			'{0, swmf_pkg::CFG_UNUSED, 0, swmf_pkg::OP_FLUSH, 8'hc3, 1, 0, 8'h00, 0},
			'{1, swmf_pkg::CFG_FRAME_WIDTH, 16'h0003, swmf_pkg::OP_PIXEL, 0, 0, 0, 0, 0},
			'{1, swmf_pkg::CFG_FRAME_HEIGHT, 16'h0002, swmf_pkg::OP_PIXEL, 0, 0, 0, 0, 0},
			'{0, swmf_pkg::CFG_UNUSED, 0, swmf_pkg::OP_PIXEL, 8'h0a, 0, 0, 0, 0},
			'{0, swmf_pkg::CFG_UNUSED, 0, swmf_pkg::OP_PIXEL, 8'hfa, 0, 0, 0, 0},
			'{0, swmf_pkg::CFG_UNUSED, 0, swmf_pkg::OP_FLUSH, 8'h00, 0, 0, 0, 0},
			'{0, swmf_pkg::CFG_UNUSED, 0, swmf_pkg::OP_PIXEL, 8'h1e, 0, 0, 0, 0},
			'{0, swmf_pkg::CFG_UNUSED, 0, swmf_pkg::OP_PIXEL, 8'h28, 0, 0, 0, 0},
			'{0, swmf_pkg::CFG_UNUSED, 0, swmf_pkg::OP_PIXEL, 8'h05, 0, 0, 0, 0},
			'{0, swmf_pkg::CFG_UNUSED, 0, swmf_pkg::OP_PIXEL, 8'h3c, 0, 0, 0, 0},
			'{0, swmf_pkg::CFG_UNUSED, 0, swmf_pkg::OP_FLUSH, 8'h00, 0, 0, 0, 0},
			'{0, swmf_pkg::CFG_UNUSED, 0, swmf_pkg::OP_PIXEL, 8'h77, 0, 0, 0, 0},
			'{0, swmf_pkg::CFG_UNUSED, 0, swmf_pkg::OP_FLUSH, 8'h00, 0, 0, 0, 0},
			'{1, swmf_pkg::CFG_FRAME_WIDTH, 16'h07ff, swmf_pkg::OP_PIXEL, 0, 0, 0, 0, 0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i]) begin
			if (table_rows[i].is_cfg) begin
				write_reg(table_rows[i].idx, table_rows[i].val);
			end else begin
				tr.pix  = table_rows[i].res_pix;
				tr.last = table_rows[i].res_last;
				send_item(table_rows[i].op, table_rows[i].pix, table_rows[i].typed,
					table_rows[i].has_res, tr);
			end
		end
		// The last pixel row, before the final width write, started a new plane over
		// the 3x2 frame; drain whatever is left.
		flush_out();

		// Random part. Idling rates rotate per phase; a few phases hit the
		// register extremes, the rest use small frames so scans stay short.
		sent  = 0;
		phase = 0;
		while (sent < RAND_ITEMS) begin
			case (phase % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 88; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 88; end
				default: begin idle_pct = 14; stall_pct = 14; end
			endcase
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 8);
			r = ($urandom_range(7) == 0) ? $urandom_range(5, 31) : $urandom_range(0, 4);
			if (phase == 4) begin
				w = MAX_WIDTH;
				h = 1;
				r = 1;
			end
			if (phase == 2) begin
				w = 4;
				h = 16'hffff;
				r = 2;
			end
			if (phase == 6)
				r = MAX_RADIUS;
			if ($urandom_range(9) == 0)
				write_reg(swmf_pkg::CFG_UNUSED, 16'($urandom));
			set_frame(w, h, r);
			if (h == 16'hffff || w == MAX_WIDTH) begin
				// Only the top of the tallest plane, or the head of the widest
				// row, is sent, then drained.
				for (int unsigned i = 0; i < lmin(3 * w, 48); i++) begin
					send_item(swmf_pkg::OP_PIXEL, 8'($urandom));
					sent++;
				end
				flush_out();
			end else begin
				repeat ($urandom_range(1, 3))
					random_plane(sent, w * h);
			end
			phase++;
		end

		drain_block();
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
